// File: hdl/ssa_pkg.sv
// ssa_pkg: shared codes, constants and the descriptor packing function
// for the segment selector allocator.
// Depends on nothing; used by hdl/segment_selector_allocator.sv and tb/testbench.sv.
package ssa_pkg;

    // Operation codes of an input word
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes of a result word
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [1:0] ST_BAD_SEL   = 2'd2;

    // Descriptor constants
    localparam logic [4:0]  TYPE_RW_DATA   = 5'h13;
    localparam logic [1:0]  DPL_USER       = 2'd3;
    localparam logic [31:0] GRAN_THRESHOLD = 32'h0010_0000;
    localparam int          GRAN_SHIFT     = 12;

    // Field widths of the ports
    localparam int SEL_IN_W  = 16;
    localparam int SEL_OUT_W = 9;
    localparam int DESC_W    = 64;

    // Pack a 32-bit data-segment descriptor; large limits switch to page
    // granularity and drop the low 12 bits.
    function automatic logic [DESC_W-1:0] build_descriptor(
        input logic [31:0] base,
        input logic [31:0] limit
    );
        logic        gran;
        logic [31:0] lim;
        gran = (limit >= GRAN_THRESHOLD);
        lim  = gran ? (limit >> GRAN_SHIFT) : limit;
        return {base[31:24], gran, 1'b1, 1'b0, 1'b0, lim[19:16],
                1'b1, DPL_USER, TYPE_RW_DATA, base[23:16], base[15:0], lim[15:0]};
    endfunction

endpackage

// File: hdl/segment_selector_allocator.sv
// segment_selector_allocator: descriptor slot free map, lowest-free-slot
// allocation and descriptor packing, with input and result registers.
// Depends on hdl/ssa_pkg.sv.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-------------------------------------------
//  request | i_valid | o_ready | i_op, i_base_addr, i_limit_value, i_selector_in
//  result  | o_valid | i_ready | o_status, o_selector_out, o_descriptor
//
// One word per cycle is accepted while results are taken; each request word is
// held in the input register and its result then in the result register.
// The free map is read and updated in the single pass out of the input register.
// Reset (synchronous, active low) empties both registers and marks every slot free.
// A stalled result holds the result register and, once the input register is
// also full, o_ready drops until the result word is taken.
module segment_selector_allocator #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [31:0] i_base_addr,
    input  logic [31:0] i_limit_value,
    input  logic [15:0] i_selector_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [8:0]  o_selector_out,
    output logic [63:0] o_descriptor
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W = ssa_pkg::SEL_IN_W - 3;

    // Input register
    logic        r_in_valid;
    logic        r_op;
    logic [31:0] r_base;
    logic [31:0] r_limit;
    logic [15:0] r_sel;

    // Result register
    logic                          r_out_valid;
    logic [1:0]                    r_status;
    logic [ssa_pkg::SEL_OUT_W-1:0] r_sel_out;
    logic [ssa_pkg::DESC_W-1:0]    r_desc;

    logic [SLOTS-1:0] r_free_map;
    logic [SLOTS-1:0] n_free_map;

    logic                          n_status;
    logic [1:0]                    n_status_code;
    logic [ssa_pkg::SEL_OUT_W-1:0] n_sel_out;
    logic [ssa_pkg::DESC_W-1:0]    n_desc;

    logic                 w_adv;
    logic                 w_found;
    logic [SW-1:0]        w_slot;
    logic [IDX_W-1:0]     w_idx;
    logic                 w_bad_sel;
    logic [15:0]          w_sel_wide;

    // Pipeline handshake
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    // Lowest free slot
    always_comb begin
        w_found = 1'b0;
        w_slot  = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (r_free_map[j]) begin
                w_found = 1'b1;
                w_slot  = SW'(j);
            end
        end
    end

    assign w_idx      = r_sel[15:3];
    assign w_bad_sel  = (w_idx == '0) || (w_idx > IDX_W'(SLOTS));
    assign w_sel_wide = (16'(w_slot) << 3) + 16'd15;

    // Result and next free map
    always_comb begin
        n_free_map    = r_free_map;
        n_status_code = ssa_pkg::ST_OK;
        n_sel_out     = '0;
        n_desc        = '0;
        if (r_op == ssa_pkg::OP_ALLOC) begin
            if (w_found) begin
                n_free_map[w_slot] = 1'b0;
                n_sel_out = w_sel_wide[ssa_pkg::SEL_OUT_W-1:0];
                n_desc    = ssa_pkg::build_descriptor(r_base, r_limit);
            end else begin
                n_status_code = ssa_pkg::ST_NO_SLOT;
            end
        end else begin
            if (w_bad_sel) begin
                n_status_code = ssa_pkg::ST_BAD_SEL;
            end else begin
                for (int j = 0; j < SLOTS; j++) begin
                    if (w_idx == IDX_W'(j + 1)) begin
                        n_free_map[j] = 1'b1;
                    end
                end
            end
        end
    end

    assign n_status = n_status_code != ssa_pkg::ST_OK;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op    <= i_op;
            r_base  <= i_base_addr;
            r_limit <= i_limit_value;
            r_sel   <= i_selector_in;
        end
    end

    // Free map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_map <= '1;
        end else if (w_adv) begin
            r_free_map <= n_free_map;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status  <= n_status_code;
            r_sel_out <= n_sel_out;
            r_desc    <= n_desc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_selector_out = r_sel_out;
    assign o_descriptor   = r_desc;

    // A failed word carries no selector and no descriptor
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_status) |=> (r_sel_out == '0 && r_desc == '0))
        else $error("failed word has nonzero selector or descriptor");

    // A successful allocate takes exactly one slot
    a_alloc_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_op == ssa_pkg::OP_ALLOC && w_found) |=>
        ($countones(r_free_map) == $countones($past(r_free_map)) - 1))
        else $error("allocate did not take exactly one slot");

    // Allocation never frees a slot
    a_alloc_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_op == ssa_pkg::OP_ALLOC) |=>
        ((r_free_map & ~$past(r_free_map)) == '0))
        else $error("allocate set a free bit");

    // The map only changes when a word passes the input register
    a_map_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_free_map))
        else $error("free map changed without a word");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for segment_selector_allocator, covering
// slot allocation, release and descriptor packing against its own predictor.
// Depends on hdl/ssa_pkg.sv and hdl/segment_selector_allocator.sv.
module testbench;

    localparam int SLOTS = 32;

    // One request word and one result word
    typedef struct {
        logic        op;
        logic [31:0] base_addr;
        logic [31:0] limit_value;
        logic [15:0] selector_in;
    } t_slot_req;

    typedef struct {
        logic [1:0]  status;
        logic [8:0]  selector_out;
        logic [63:0] descriptor;
    } t_slot_reply;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_op          = ssa_pkg::OP_ALLOC;
    logic [31:0] i_base_addr   = '0;
    logic [31:0] i_limit_value = '0;
    logic [15:0] i_selector_in = '0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [8:0]  o_selector_out;
    logic [63:0] o_descriptor;

    t_slot_req   req_backlog[$];
    t_slot_reply expected_replies[$];
    t_slot_req   cur_req;
    t_slot_reply want;
    logic [SLOTS-1:0] slots_free;
    int          send_gap    = 0;
    int          sent_cnt    = 0;
    int          stall_left  = 0;
    int          cycle_cnt   = 0;
    int          reply_cnt   = 0;
    int          error_cnt   = 0;

    segment_selector_allocator #(.SLOTS(SLOTS)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_base_addr    (i_base_addr),
        .i_limit_value  (i_limit_value),
        .i_selector_in  (i_selector_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_selector_out (o_selector_out),
        .o_descriptor   (o_descriptor)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Data-segment descriptor: page granularity for limits of 1 MiB and up
    function automatic logic [63:0] pack_descriptor(input logic [31:0] base,
                                                    input logic [31:0] limit);
        logic        page;
        logic [31:0] lim;
        logic [63:0] d;
        page = (limit >= ssa_pkg::GRAN_THRESHOLD);
        lim  = page ? (limit >> ssa_pkg::GRAN_SHIFT) : limit;
        d = '0;
        d[15:0]  = lim[15:0];
        d[31:16] = base[15:0];
        d[39:32] = base[23:16];
        d[44:40] = ssa_pkg::TYPE_RW_DATA;
        d[46:45] = ssa_pkg::DPL_USER;
        d[47]    = 1'b1;
        d[51:48] = lim[19:16];
        d[54]    = 1'b1;
        d[55]    = page;
        d[63:56] = base[31:24];
        return d;
    endfunction

    // Apply one request word to the local free map and return its reply
    function automatic t_slot_reply predict_slot_op(input t_slot_req r);
        t_slot_reply res;
        int          idx;
        bit          found;
        res.status       = ssa_pkg::ST_OK;
        res.selector_out = '0;
        res.descriptor   = '0;
        found = 1'b0;
        if (r.op == ssa_pkg::OP_ALLOC) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (!found && slots_free[s]) begin
                    found = 1'b1;
                    slots_free[s] = 1'b0;
                    res.selector_out = 9'(s * 8 + 15);
                    res.descriptor   = pack_descriptor(r.base_addr, r.limit_value);
                end
            end
            if (!found) begin
                res.status = ssa_pkg::ST_NO_SLOT;
            end
        end else begin
            // low three selector bits do not pick the slot
            idx = int'(r.selector_in >> 3);
            if (idx == 0 || idx > SLOTS) begin
                res.status = ssa_pkg::ST_BAD_SEL;
            end else begin
                slots_free[idx-1] = 1'b1;
            end
        end
        return res;
    endfunction

    // Idle lengths: mostly short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_limit();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) return $urandom_range(0, 32'h000F_FFFF);
        if (roll < 8) return $urandom();
        return ssa_pkg::GRAN_THRESHOLD + $urandom_range(0, 4) - 2;
    endfunction

    function automatic logic [15:0] pick_selector();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return {3'b000, 10'($urandom_range(1, SLOTS)), 3'($urandom_range(0, 7))};
        if (roll < 95) return 16'($urandom());
        if (roll < 98) return 16'($urandom_range(0, 7));
        return 16'($urandom_range((SLOTS + 1) * 8, 16'hFFFF));
    endfunction

    task automatic queue_req(input logic op, input logic [31:0] base,
                             input logic [31:0] limit, input logic [15:0] sel);
        t_slot_req r;
        r.op          = op;
        r.base_addr   = base;
        r.limit_value = limit;
        r.selector_in = sel;
        req_backlog.push_back(r);
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] exp_val);
        $display("reply %0d: %s got 0x%0h, want 0x%0h", reply_cnt, field, got, exp_val);
        error_cnt++;
    endtask

    // Request driver: predicts each word as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_replies.push_back(predict_slot_op(cur_req));
            end
            if (!i_valid || o_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    cur_req = req_backlog.pop_front();
                    i_valid       <= 1'b1;
                    i_op          <= cur_req.op;
                    i_base_addr   <= cur_req.base_addr;
                    i_limit_value <= cur_req.limit_value;
                    i_selector_in <= cur_req.selector_in;
                    // every third stretch of words goes back to back
                    if ((sent_cnt % 300) < 100 || $urandom_range(0, 1) == 0) begin
                        send_gap = 0;
                    end else begin
                        send_gap = pick_gap();
                    end
                    sent_cnt++;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor and ready stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            cycle_cnt++;
            if (o_valid && i_ready) begin
                if (expected_replies.size() == 0) begin
                    note_mismatch("unexpected word, status", 64'(o_status), 64'(0));
                end else begin
                    want = expected_replies.pop_front();
                    if (o_status !== want.status)
                        note_mismatch("status", 64'(o_status), 64'(want.status));
                    if (o_selector_out !== want.selector_out)
                        note_mismatch("selector", 64'(o_selector_out), 64'(want.selector_out));
                    if (o_descriptor !== want.descriptor)
                        note_mismatch("descriptor", o_descriptor, want.descriptor);
                end
                reply_cnt++;
            end
            if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ((cycle_cnt % 600) >= 200 && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int phase_kind;
        int phase_len;
        int free_pct;
        int rand_cnt;
        slots_free = '1;

        // directed: field extremes, threshold, selector corner cases
        queue_req(ssa_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        queue_req(ssa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        queue_req(ssa_pkg::OP_ALLOC, 32'h1234_5678, 32'h000F_FFFF, 16'h0008);
        queue_req(ssa_pkg::OP_ALLOC, 32'hA5C3_0F96, ssa_pkg::GRAN_THRESHOLD, 16'h0010);
        queue_req(ssa_pkg::OP_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        queue_req(ssa_pkg::OP_FREE,  32'h0000_0000, 32'h0000_0000, 16'h0007);
        queue_req(ssa_pkg::OP_FREE,  32'h0000_0000, 32'h0000_0000, 16'((SLOTS + 1) * 8));
        queue_req(ssa_pkg::OP_FREE,  32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        queue_req(ssa_pkg::OP_FREE,  32'h0000_0000, 32'h0000_0000, 16'h000F);
        queue_req(ssa_pkg::OP_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h000B);
        queue_req(ssa_pkg::OP_ALLOC, 32'h8000_0001, 32'h0010_0FFF, 16'h5555);
        queue_req(ssa_pkg::OP_FREE,  32'h0000_0000, 32'h0000_0000, 16'(SLOTS * 8));
        queue_req(ssa_pkg::OP_FREE,  32'h0000_0000, 32'h0000_0000, 16'h0017);
        queue_req(ssa_pkg::OP_ALLOC, $urandom(), $urandom(), 16'hAAAA);
        queue_req(ssa_pkg::OP_FREE,  $urandom(), $urandom(), 16'h0018);
        queue_req(ssa_pkg::OP_ALLOC, 32'h00FF_0000, 32'h7FFF_FFFF, 16'h0000);
        queue_req(ssa_pkg::OP_ALLOC, 32'h0000_FFFF, 32'h0000_FFFF, 16'h0000);

        // random: fill, drain and mixed phases so the map runs full and empty
        rand_cnt = 0;
        while (rand_cnt < 1500) begin
            phase_kind = $urandom_range(0, 2);
            phase_len  = $urandom_range(20, 80);
            free_pct   = (phase_kind == 0) ? 10 : (phase_kind == 1) ? 80 : 50;
            for (int k = 0; k < phase_len; k++) begin
                queue_req(($urandom_range(0, 99) < free_pct) ?
                              ssa_pkg::OP_FREE : ssa_pkg::OP_ALLOC,
                          $urandom(), pick_limit(), pick_selector());
                rand_cnt++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || i_valid || expected_replies.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
